@@ design/segint_pkg.sv @@
`timescale 1ns / 1ps
// Package for the segment intersection block.
// Holds the control group that steps the divider cells; no dependencies.
package segint_pkg;

   typedef struct packed {
      logic enable;
      logic valid;
   } segint_ctl_type;

endpackage

@@ design/segint_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring division step for the x and y quotients of one transaction.
// Depends on segint_pkg for the control group.
module segint_div_cell #(
   parameter int DMW = 35,
   parameter int QW  = 17,
   parameter int PW  = 131
) (
   input  logic                    clock,
   input  logic                    reset,
   input  segint_pkg::segint_ctl_type ctl_i,
   input  logic [DMW-1:0]          d_i,
   input  logic [DMW-1:0]          rem_x_i,
   input  logic [QW-1:0]           nq_x_i,
   input  logic [DMW-1:0]          rem_y_i,
   input  logic [QW-1:0]           nq_y_i,
   input  logic [PW-1:0]           side_i,
   output logic                    valid_o,
   output logic [DMW-1:0]          d_o,
   output logic [DMW-1:0]          rem_x_o,
   output logic [QW-1:0]           nq_x_o,
   output logic [DMW-1:0]          rem_y_o,
   output logic [QW-1:0]           nq_y_o,
   output logic [PW-1:0]           side_o
);
   import segint_pkg::*;

   logic           valid_ff;
   logic [DMW-1:0] d_ff, rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QW-1:0]  nq_x_ff, nq_y_ff, nq_x_in, nq_y_in;
   logic [PW-1:0]  side_ff;
   logic [DMW:0]   tx, ty, dd;
   logic           gex, gey;

   always_comb begin
      dd = {1'b0, d_i};
      tx = {rem_x_i, nq_x_i[QW-1]};
      ty = {rem_y_i, nq_y_i[QW-1]};
      gex = tx >= dd;
      gey = ty >= dd;
      rem_x_in = gex ? DMW'(tx - dd) : tx[DMW-1:0];
      rem_y_in = gey ? DMW'(ty - dd) : ty[DMW-1:0];
      nq_x_in = {nq_x_i[QW-2:0], gex};
      nq_y_in = {nq_y_i[QW-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_i.enable) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_i.enable) begin
         d_ff     <= d_i;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         nq_x_ff  <= nq_x_in;
         nq_y_ff  <= nq_y_in;
         side_ff  <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign d_o     = d_ff;
   assign rem_x_o = rem_x_ff;
   assign rem_y_o = rem_y_ff;
   assign nq_x_o  = nq_x_ff;
   assign nq_y_o  = nq_y_ff;
   assign side_o  = side_ff;

endmodule

@@ design/segment_intersection.sv @@
`timescale 1ns / 1ps
// Top level of the segment intersection block: products, numerators and a row of
// division cells. Depends on segint_pkg and segint_div_cell.
//
// Channel   Direction  Handshake              Content
// req_      in         req_tvalid/req_tready  eight endpoint coordinates
// rsp_      out        rsp_tvalid/rsp_tready  crossing point, hit flag in tuser
//
// One transaction is accepted every cycle while the result side is not stalled; the
// pipeline is made of seven arithmetic stages, one division cell per quotient bit and
// the output register. Reset clears the valid bits only. A stall on the result side
// holds the whole pipeline, and req_tready falls only while a result waits.
module segment_intersection #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [8*COORD_WIDTH-1:0]      req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // cross_x, cross_y, zero fill
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic                          rsp_tuser
);
   import segint_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int DXW  = W + 1;
   localparam int PPW  = 2 * W + 2;
   localparam int DETW = 2 * W + 3;
   localparam int PRW  = 2 * W + 1;
   localparam int NUMW = 3 * W + 4;
   localparam int DMW  = DETW;
   localparam int QW   = W + 1;
   localparam int VW   = W + 2;
   localparam int PW   = 8 * W + 3;
   localparam int OW   = ((2 * W + 7) / 8) * 8;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, out_valid_ff;

   assign en = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Stage 1: coordinates and direction vectors.
   logic signed [W-1:0]   c1_ff [8];
   logic signed [DXW-1:0] dx12_1_ff, dy12_1_ff, dx34_1_ff, dy34_1_ff;
   logic signed [W-1:0]   cin [8];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         cin[i] = $signed(req_tdata[i*W +: W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) begin
            c1_ff[i] <= cin[i];
         end
         dx12_1_ff <= DXW'(cin[0]) - DXW'(cin[2]);
         dy12_1_ff <= DXW'(cin[1]) - DXW'(cin[3]);
         dx34_1_ff <= DXW'(cin[4]) - DXW'(cin[6]);
         dy34_1_ff <= DXW'(cin[5]) - DXW'(cin[7]);
      end
   end

   // Stage 2: first products.
   logic signed [W-1:0]     c2_ff [8];
   logic signed [DXW-1:0]   dx12_2_ff, dy12_2_ff, dx34_2_ff, dy34_2_ff;
   logic signed [PPW-1:0]   da_ff, db_ff;
   logic signed [2*W-1:0]   pa_ff, pb_ff, qa_ff, qb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff     <= c1_ff;
         dx12_2_ff <= dx12_1_ff;
         dy12_2_ff <= dy12_1_ff;
         dx34_2_ff <= dx34_1_ff;
         dy34_2_ff <= dy34_1_ff;
         da_ff <= dx12_1_ff * dy34_1_ff;
         db_ff <= dy12_1_ff * dx34_1_ff;
         pa_ff <= c1_ff[0] * c1_ff[3];
         pb_ff <= c1_ff[1] * c1_ff[2];
         qa_ff <= c1_ff[4] * c1_ff[7];
         qb_ff <= c1_ff[5] * c1_ff[6];
      end
   end

   // Stage 3: determinant and line constants.
   logic signed [W-1:0]    c3_ff [8];
   logic signed [DXW-1:0]  dx12_3_ff, dy12_3_ff, dx34_3_ff, dy34_3_ff;
   logic signed [DETW-1:0] det3_ff;
   logic signed [PRW-1:0]  pre_ff, post_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff     <= c2_ff;
         dx12_3_ff <= dx12_2_ff;
         dy12_3_ff <= dy12_2_ff;
         dx34_3_ff <= dx34_2_ff;
         dy34_3_ff <= dy34_2_ff;
         det3_ff <= DETW'(da_ff) - DETW'(db_ff);
         pre_ff  <= PRW'(pa_ff) - PRW'(pb_ff);
         post_ff <= PRW'(qa_ff) - PRW'(qb_ff);
      end
   end

   // Stage 4: partial products of the numerators, split at bit W.
   logic signed [DXW-1:0]  pre_lo, pre_hi, post_lo, post_hi;
   logic signed [W-1:0]    c4_ff [8];
   logic signed [DETW-1:0] det4_ff;
   logic signed [PPW-1:0]  xpl_ff, xph_ff, xql_ff, xqh_ff;
   logic signed [PPW-1:0]  ypl_ff, yph_ff, yql_ff, yqh_ff;

   always_comb begin
      pre_lo  = $signed({1'b0, pre_ff[W-1:0]});
      pre_hi  = $signed(pre_ff[PRW-1:W]);
      post_lo = $signed({1'b0, post_ff[W-1:0]});
      post_hi = $signed(post_ff[PRW-1:W]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff   <= c3_ff;
         det4_ff <= det3_ff;
         xpl_ff  <= pre_lo * dx34_3_ff;
         xph_ff  <= pre_hi * dx34_3_ff;
         xql_ff  <= dx12_3_ff * post_lo;
         xqh_ff  <= dx12_3_ff * post_hi;
         ypl_ff  <= pre_lo * dy34_3_ff;
         yph_ff  <= pre_hi * dy34_3_ff;
         yql_ff  <= dy12_3_ff * post_lo;
         yqh_ff  <= dy12_3_ff * post_hi;
      end
   end

   // Stage 5: numerators.
   logic signed [W-1:0]    c5_ff [8];
   logic signed [DETW-1:0] det5_ff;
   logic signed [NUMW-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff   <= c4_ff;
         det5_ff <= det4_ff;
         numx_ff <= ((NUMW'(xph_ff) <<< W) + NUMW'(xpl_ff))
                  - ((NUMW'(xqh_ff) <<< W) + NUMW'(xql_ff));
         numy_ff <= ((NUMW'(yph_ff) <<< W) + NUMW'(ypl_ff))
                  - ((NUMW'(yqh_ff) <<< W) + NUMW'(yql_ff));
      end
   end

   // Stage 6: magnitudes and quotient signs.
   logic signed [W-1:0] c6_ff [8];
   logic [NUMW-1:0]     nxm_ff, nym_ff;
   logic [DMW-1:0]      dm_ff;
   logic                negx_ff, negy_ff, detnz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c6_ff    <= c5_ff;
         nxm_ff   <= numx_ff[NUMW-1] ? NUMW'(-numx_ff) : NUMW'(numx_ff);
         nym_ff   <= numy_ff[NUMW-1] ? NUMW'(-numy_ff) : NUMW'(numy_ff);
         dm_ff    <= det5_ff[DETW-1] ? DMW'(-det5_ff) : DMW'(det5_ff);
         negx_ff  <= numx_ff[NUMW-1] ^ det5_ff[DETW-1];
         negy_ff  <= numy_ff[NUMW-1] ^ det5_ff[DETW-1];
         detnz_ff <= det5_ff != '0;
      end
   end

   // Stage 7: range check of the quotient and start of the division.
   logic [NUMW-1:0] hix, hiy;
   logic            ovfx, ovfy;
   logic [DMW-1:0]  d_ch [QW+1];
   logic [DMW-1:0]  rx_ch [QW+1];
   logic [DMW-1:0]  ry_ch [QW+1];
   logic [QW-1:0]   qx_ch [QW+1];
   logic [QW-1:0]   qy_ch [QW+1];
   logic [PW-1:0]   side_ch [QW+1];
   logic            v_ch [QW+1];
   logic [DMW-1:0]  d7_ff, rx7_ff, ry7_ff;
   logic [QW-1:0]   qx7_ff, qy7_ff;
   logic [PW-1:0]   side7_ff;
   logic [8*W-1:0]  cpack;

   always_comb begin
      hix  = nxm_ff >> QW;
      hiy  = nym_ff >> QW;
      ovfx = hix >= NUMW'(dm_ff);
      ovfy = hiy >= NUMW'(dm_ff);
      for (int i = 0; i < 8; i++) begin
         cpack[i*W +: W] = c6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d7_ff    <= dm_ff;
         rx7_ff   <= hix[DMW-1:0];
         ry7_ff   <= hiy[DMW-1:0];
         qx7_ff   <= nxm_ff[QW-1:0];
         qy7_ff   <= nym_ff[QW-1:0];
         side7_ff <= {detnz_ff && !ovfx && !ovfy, negy_ff, negx_ff, cpack};
      end
   end

   assign v_ch[0]    = v7_ff;
   assign d_ch[0]    = d7_ff;
   assign rx_ch[0]   = rx7_ff;
   assign ry_ch[0]   = ry7_ff;
   assign qx_ch[0]   = qx7_ff;
   assign qy_ch[0]   = qy7_ff;
   assign side_ch[0] = side7_ff;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      segint_ctl_type ctl;
      assign ctl.enable = en;
      assign ctl.valid  = v_ch[g];
      segint_div_cell #(.DMW(DMW), .QW(QW), .PW(PW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_i   (ctl),
         .d_i     (d_ch[g]),
         .rem_x_i (rx_ch[g]),
         .nq_x_i  (qx_ch[g]),
         .rem_y_i (ry_ch[g]),
         .nq_y_i  (qy_ch[g]),
         .side_i  (side_ch[g]),
         .valid_o (v_ch[g+1]),
         .d_o     (d_ch[g+1]),
         .rem_x_o (rx_ch[g+1]),
         .nq_x_o  (qx_ch[g+1]),
         .rem_y_o (ry_ch[g+1]),
         .nq_y_o  (qy_ch[g+1]),
         .side_o  (side_ch[g+1])
      );
   end

   // Output stage: signed quotients and the bounds test.
   logic [PW-1:0]        sd;
   logic signed [VW-1:0] qsx, qsy;
   logic signed [VW-1:0] e [8];
   logic                 inx, iny, hit_in;
   logic                 hit_ff;
   logic [W-1:0]         cx_ff, cy_ff;

   function automatic logic within_range(input logic signed [VW-1:0] v,
                                         input logic signed [VW-1:0] a,
                                         input logic signed [VW-1:0] b);
      logic signed [VW-1:0] lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (v >= lo) && (v <= hi);
   endfunction

   always_comb begin
      sd = side_ch[QW];
      qsx = sd[8*W] ? -$signed(VW'(qx_ch[QW])) : $signed(VW'(qx_ch[QW]));
      qsy = sd[8*W+1] ? -$signed(VW'(qy_ch[QW])) : $signed(VW'(qy_ch[QW]));
      for (int i = 0; i < 8; i++) begin
         e[i] = VW'($signed(sd[i*W +: W]));
      end
      inx = within_range(qsx, e[0], e[2]) && within_range(qsx, e[4], e[6]);
      iny = within_range(qsy, e[1], e[3]) && within_range(qsy, e[5], e[7]);
      hit_in = sd[8*W+2] && inx && iny;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ch[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         cx_ff  <= hit_in ? qsx[W-1:0] : '0;
         cy_ff  <= hit_in ? qsy[W-1:0] : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OW'({cy_ff, cx_ff});
   assign rsp_tuser  = hit_ff;

endmodule

@@ verif/segment_intersection_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for segment_intersection: drives pairs of segments on the
// request stream and checks each response against an exact integer crossing predictor.
// Depends on the segment_intersection RTL only.
module segment_intersection_tb;

   localparam int CW = 16;
   localparam int DW = ((2*CW+7)/8)*8;
   localparam int LATENCY = CW + 9;
   localparam int N_RANDOM = 1550;
   localparam longint LIMIT = 400000;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed {
      logic      hit;
      coord_type cx;
      coord_type cy;
   } crossing_type;
   typedef struct {
      coord_type    c[8];
      logic         known;
      crossing_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [8*CW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic rsp_tuser;

   crossing_type crossings_due[$];
   int  failures = 0;
   longint cycle = 0;
   bit  hold_rsp = 1'b0;
   bit  calm = 1'b0;

   segment_intersection #(.COORD_WIDTH(CW)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic logic in_span(longint v, longint a, longint b);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (v >= lo) && (v <= hi);
   endfunction

   // Products stay within 128 bits with 16-bit coordinates; division truncates.
   function automatic crossing_type segment_crossing(coord_type c[8]);
      logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
      logic signed [127:0] dx12, dy12, dx34, dy34, det, pre, post, qx, qy;
      crossing_type r;
      x1 = 128'(c[0]); y1 = 128'(c[1]); x2 = 128'(c[2]); y2 = 128'(c[3]);
      x3 = 128'(c[4]); y3 = 128'(c[5]); x4 = 128'(c[6]); y4 = 128'(c[7]);
      r = '0;
      dx12 = x1 - x2; dy12 = y1 - y2; dx34 = x3 - x4; dy34 = y3 - y4;
      det = dx12 * dy34 - dy12 * dx34;
      if (det == 0) return r;
      pre = x1 * y2 - y1 * x2;
      post = x3 * y4 - y3 * x4;
      qx = (pre * dx34 - dx12 * post) / det;
      qy = (pre * dy34 - dy12 * post) / det;
      if (qx > 128'sd100000 || qx < -128'sd100000) return r;
      if (qy > 128'sd100000 || qy < -128'sd100000) return r;
      if (!in_span(longint'(qx), longint'(x1), longint'(x2)) ||
          !in_span(longint'(qx), longint'(x3), longint'(x4))) return r;
      if (!in_span(longint'(qy), longint'(y1), longint'(y2)) ||
          !in_span(longint'(qy), longint'(y3), longint'(y4))) return r;
      r.hit = 1'b1;
      r.cx = qx[CW-1:0];
      r.cy = qy[CW-1:0];
      return r;
   endfunction

   function automatic row_type mk(int a, int b, int c, int d, int e, int f, int g, int h,
                                  logic k = 1'b0, logic hh = 1'b0, int wx = 0, int wy = 0);
      row_type r;
      r.c[0] = coord_type'(a); r.c[1] = coord_type'(b);
      r.c[2] = coord_type'(c); r.c[3] = coord_type'(d);
      r.c[4] = coord_type'(e); r.c[5] = coord_type'(f);
      r.c[6] = coord_type'(g); r.c[7] = coord_type'(h);
      r.known = k;
      r.want.hit = hh; r.want.cx = coord_type'(wx); r.want.cy = coord_type'(wy);
      return r;
   endfunction

   row_type directed[$];

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("segment_intersection regression: fail");
         $finish;
      end
   end

   // Response side: random back-pressure bursts, plus one long hold-off.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      crossing_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tuser;
         got.cx = rsp_tdata[CW-1:0];
         got.cy = rsp_tdata[2*CW-1:CW];
         if (crossings_due.size() == 0) begin
            $error("unexpected transaction: hit %0b x %0d y %0d", got.hit, got.cx, got.cy);
            failures++;
         end else begin
            want = crossings_due.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, got.hit); failures++;
            end
            if (got.cx !== want.cx) begin
               $error("cross_x: expected %0d, actual %0d", want.cx, got.cx); failures++;
            end
            if (got.cy !== want.cy) begin
               $error("cross_y: expected %0d, actual %0d", want.cy, got.cy); failures++;
            end
         end
      end
   end

   task automatic send_pair(row_type r);
      crossing_type w;
      w = segment_crossing(r.c);
      if (r.known && w !== r.want) begin
         $error("table row: expected %p, predicted %p", r.want, w);
         failures++;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.c[7], r.c[6], r.c[5], r.c[4], r.c[3], r.c[2], r.c[1], r.c[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      crossings_due.push_back(w);
   endtask

   task automatic gap();
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic coord_type rnd_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 2*span) - span);
   endfunction

   function automatic row_type rnd_row();
      row_type r;
      int kind, span, px, py;
      kind = $urandom_range(0, 9);
      span = ($urandom_range(0, 1)) ? 0 : 300;
      for (int i = 0; i < 8; i++) r.c[i] = rnd_coord(span);
      if (kind < 5) begin
         // Segments built around a shared point so that many pairs do cross.
         px = int'(rnd_coord(span == 0 ? 16000 : 200));
         py = int'(rnd_coord(span == 0 ? 16000 : 200));
         r.c[2] = coord_type'(2*px - int'(r.c[0]));
         r.c[3] = coord_type'(2*py - int'(r.c[1]));
         r.c[6] = coord_type'(2*px - int'(r.c[4]));
         r.c[7] = coord_type'(2*py - int'(r.c[5]));
      end else if (kind == 5) begin
         r.c[4] = coord_type'(int'(r.c[0]) + 7); r.c[5] = r.c[1];
         r.c[6] = coord_type'(int'(r.c[2]) + 7); r.c[7] = r.c[3];
      end else if (kind == 6) begin
         r.c[2] = r.c[0];
         r.c[6] = coord_type'(int'(r.c[4]) + int'($urandom_range(0, 3)));
      end
      r.known = 1'b0;
      return r;
   endfunction

   initial begin
      directed.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0, 1, 1, 5, 5));
      directed.push_back(mk(0, 0, 10, 0, 0, 5, 10, 5, 1, 0, 0, 0));
      directed.push_back(mk(0, 0, 10, 10, 5, 5, 20, 20, 1, 0, 0, 0));
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(mk(0, 0, 10, 10, 20, 0, 30, -10, 1, 0, 0, 0));
      directed.push_back(mk(0, 0, 10, 0, 10, -5, 10, 5, 1, 1, 10, 0));
      directed.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                            1, 1, 0, 0));
      directed.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1, 1, 0, 0));
      directed.push_back(mk(32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767,
                            1, 1, 32767, 32767));
      directed.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768,
                            1, 1, -32768, -32768));
      directed.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0));
      directed.push_back(mk(0, 0, -3, -1, 0, -1, -3, 0));
      directed.push_back(mk(-1, -1, -1, -1, 32767, 32767, -32768, -32768));
      directed.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
      directed.push_back(mk(0, 0, 1, 32767, 1, 0, 0, 32767));
      directed.push_back(mk(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_pair(directed[i]);
         gap();
      end
      req_tvalid <= 1'b0;
      while (crossings_due.size() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 300) hold_rsp = 1'b1;
         if (i == 700) begin
            req_tvalid <= 1'b0;
            while (crossings_due.size() != 0) @(posedge clock);
         end
         if (i == N_RANDOM - 200) calm = 1'b1;
         send_pair(rnd_row());
         gap();
      end
      req_tvalid <= 1'b0;

      while (crossings_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0) begin
         $display("segment_intersection regression: pass");
      end else begin
         $display("segment_intersection regression: fail");
      end
      $finish;
   end

endmodule
